// ===== src/udf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udf_pkg: shared types and constants of the update frame deframer
// Item and result layouts, event codes and the framing constants used by
// the input stage, the frame core, the output stage and the checker.
// ----------------------------------------------------------------------------
package udf_pkg;

  localparam int PACK_SIZE = 512;
  localparam int MAX_LEN   = PACK_SIZE + 10;

  localparam int POS_W  = 10;
  localparam int TICK_W = 4;
  localparam int LEN_W  = 17;

  localparam logic [7:0] START_BYTE = 8'h69;
  localparam logic [7:0] END_BYTE   = 8'h17;

  localparam logic [7:0] FT_LONG_A  = 8'd0;
  localparam logic [7:0] FT_SHORT_A = 8'd1;
  localparam logic [7:0] FT_SHORT_B = 8'd2;
  localparam logic [7:0] FT_SHORT_C = 8'd3;
  localparam logic [7:0] FT_LONG_B  = 8'd6;

  localparam logic [POS_W-1:0] SHORT_LEN   = POS_W'(10);
  localparam logic [LEN_W-1:0] LEN_BIAS    = LEN_W'(8);
  localparam logic [POS_W-1:0] LEN_POS     = POS_W'(5);
  localparam logic [POS_W-1:0] LEN_LOW_POS = POS_W'(4);
  localparam logic [POS_W-1:0] TYPE_POS    = POS_W'(1);

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(3);

  typedef enum logic [2:0] {
    EV_DATA     = 3'd0,
    EV_LEN_OVF  = 3'd1,
    EV_BAD_END  = 3'd2,
    EV_BAD_TYPE = 3'd3,
    EV_TIMEOUT  = 3'd4
  } event_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_t           event_res;
    logic [7:0]       byte_out;
    logic [POS_W-1:0] position;
    logic             last;
    logic             checksum_ok;
    logic [7:0]       frame_kind;
  } result_t;

endpackage
`default_nettype wire

// ===== src/udf_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udf_in_stage: input register
// Holds one accepted transaction until the frame core consumes it.
// ----------------------------------------------------------------------------
module udf_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire udf_pkg::item_t in_item,
  input  wire logic          step,
  output logic               item_vld,
  output udf_pkg::item_t     item
);
  import udf_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = vld_r && !step;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load ? 1'b1 : (step ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule
`default_nettype wire

// ===== src/udf_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udf_core: frame state and per-item decision logic
// Tracks the open frame, its length, checksum and tick count, and forms
// the result of one item in a single pass.
// ----------------------------------------------------------------------------
module udf_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [3:0]     cfg_wr_data,
  input  wire logic           step,
  input  wire udf_pkg::item_t item,
  output logic                res_vld,
  output udf_pkg::result_t    res
);
  import udf_pkg::*;

  logic [TICK_W-1:0] limit_r;
  logic              in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              match_r, match_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  logic [TICK_W:0]   tick_inc;
  logic [LEN_W-1:0]  len_full;
  logic [POS_W-1:0]  len_eff;
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    len_ext;
  logic              bad_type;
  logic              bad_len;
  logic [7:0]        b;

  assign b        = item.rx_byte;
  assign tick_inc = {1'b0, tick_r} + (TICK_W + 1)'(1);
  assign len_full = LEN_W'({b, low_r}) + LEN_BIAS;
  assign pos_ext  = {1'b0, cnt_r};

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    low_nxt      = low_r;
    sum_nxt      = sum_r;
    match_nxt    = match_r;
    type_nxt     = type_r;
    tick_nxt     = tick_r;
    len_eff      = len_r;
    bad_type     = 1'b0;
    bad_len      = 1'b0;
    res_vld          = 1'b0;
    res.event_res    = EV_DATA;
    res.byte_out     = b;
    res.position     = cnt_r;
    res.last         = 1'b0;
    res.checksum_ok  = 1'b0;
    res.frame_kind   = type_r;

    if (item.func) begin
      if (in_frame_r) begin
        if (tick_inc > {1'b0, limit_r}) begin
          in_frame_nxt  = 1'b0;
          res_vld       = 1'b1;
          res.event_res = EV_TIMEOUT;
          res.byte_out  = '0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
    end else if (!in_frame_r) begin
      if (b == START_BYTE) begin
        in_frame_nxt   = 1'b1;
        cnt_nxt        = POS_W'(1);
        len_nxt        = '0;
        low_nxt        = '0;
        sum_nxt        = '0;
        match_nxt      = 1'b0;
        type_nxt       = '0;
        tick_nxt       = '0;
        res_vld        = 1'b1;
        res.position   = '0;
        res.frame_kind = '0;
      end
    end else begin
      cnt_nxt = cnt_r + POS_W'(1);
      res_vld = 1'b1;
      if (cnt_r == TYPE_POS) begin
        type_nxt       = b;
        res.frame_kind = b;
      end
      if (cnt_r == LEN_LOW_POS) begin
        low_nxt = b;
      end
      if (cnt_r == LEN_POS) begin
        priority if (type_r == FT_SHORT_A || type_r == FT_SHORT_B || type_r == FT_SHORT_C) begin
          len_eff = SHORT_LEN;
        end else if (type_r == FT_LONG_A || type_r == FT_LONG_B) begin
          if (len_full > LEN_W'(MAX_LEN)) begin
            bad_len = 1'b1;
          end else begin
            len_eff = len_full[POS_W-1:0];
          end
        end else begin
          bad_type = 1'b1;
        end
      end

      if (bad_type) begin
        in_frame_nxt  = 1'b0;
        res.event_res = EV_BAD_TYPE;
      end else if (bad_len) begin
        in_frame_nxt  = 1'b0;
        res.event_res = EV_LEN_OVF;
      end else begin
        len_nxt = len_eff;
        priority if (len_eff == '0 || (pos_ext + (POS_W + 1)'(3)) <= len_ext) begin
          sum_nxt = sum_r + b;
        end else if ((pos_ext + (POS_W + 1)'(2)) == len_ext) begin
          match_nxt = (sum_r == b);
        end else if ((pos_ext + (POS_W + 1)'(1)) == len_ext) begin
          in_frame_nxt = 1'b0;
          if (b != END_BYTE) begin
            res.event_res = EV_BAD_END;
          end else begin
            res.last        = 1'b1;
            res.checksum_ok = match_r;
          end
        end else begin
          sum_nxt = sum_r;
        end
      end
    end
  end

  assign len_ext = {1'b0, len_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      len_r      <= '0;
      low_r      <= '0;
      sum_r      <= '0;
      match_r    <= 1'b0;
      type_r     <= '0;
      tick_r     <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      low_r      <= low_nxt;
      sum_r      <= sum_nxt;
      match_r    <= match_nxt;
      type_r     <= type_nxt;
      tick_r     <= tick_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/udf_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udf_out_stage: result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module udf_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             res_vld,
  input  wire udf_pkg::result_t res,
  input  wire logic             out_stall,
  output logic                  out_vld,
  output udf_pkg::result_t      out_res
);
  import udf_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (step) begin
      vld_nxt = res_vld;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      res_r <= res;
    end
  end

  assign out_vld = vld_r;
  assign out_res = res_r;

endmodule
`default_nettype wire

// ===== src/update_frame_deframer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// update_frame_deframer_unit: start/end byte deframer with sum checksum
// Takes received bytes and timer ticks, tracks frames that open on the
// start byte, checks type, length, checksum and end byte, and reports every
// frame byte or abort as one result transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_stall   in_func, in_rx_byte
//  out_      output     out_valid / out_stall out_event_res .. out_frame_kind
//  cfg_      input      cfg_wr_en             cfg_wr_data (timeout limit)
//
// One transaction is accepted every cycle while in_stall is low; the input is
// held in the input register and its result, where it gives one, in the result
// register before the result is valid on the outputs.
// Reset is synchronous and active low; the timeout limit returns to 3.
// A stalled result holds the core, and the input then stalls in the same cycle.
// ----------------------------------------------------------------------------
module update_frame_deframer_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_func,
  input  wire logic [7:0]                in_rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_event_res,
  output logic [7:0]                     out_byte_out,
  output logic [udf_pkg::POS_W-1:0]      out_position,
  output logic                           out_last,
  output logic                           out_checksum_ok,
  output logic [7:0]                     out_frame_kind,
  input  wire logic                      cfg_wr_en,
  input  wire logic [3:0]                cfg_wr_data
);
  import udf_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    step;
  logic    res_vld;
  result_t res;
  result_t out_res;

  assign in_item.func    = in_func;
  assign in_item.rx_byte = in_rx_byte;
  assign step            = item_vld && (!out_valid || !out_stall);

  udf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .step     (step),
    .item_vld (item_vld),
    .item     (item)
  );

  udf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (item),
    .res_vld     (res_vld),
    .res         (res)
  );

  udf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_vld   (out_valid),
    .out_res   (out_res)
  );

  assign out_event_res   = out_res.event_res;
  assign out_byte_out    = out_res.byte_out;
  assign out_position    = out_res.position;
  assign out_last        = out_res.last;
  assign out_checksum_ok = out_res.checksum_ok;
  assign out_frame_kind  = out_res.frame_kind;

endmodule
`default_nettype wire

// ===== src/udf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udf_checker: port-level checks of the update frame deframer
// Watches the result channel for stable stalled results and for consistency between event, byte and flags.
// ----------------------------------------------------------------------------
module udf_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic [2:0]                out_event_res,
  input  wire logic [7:0]                out_byte_out,
  input  wire logic [udf_pkg::POS_W-1:0] out_position,
  input  wire logic                      out_last,
  input  wire logic                      out_checksum_ok,
  input  wire logic [7:0]                out_frame_kind
);
  import udf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_byte_out) && $stable(out_position))
    else $error("Stalled result transaction changed.");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_event_res == EV_DATA && out_byte_out == END_BYTE)
    else $error("Frame end reported on a byte other than the end byte.");

  a_ok_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_last)
    else $error("Checksum flag raised outside a frame end.");

  a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_TIMEOUT |-> out_byte_out == 8'd0 && !out_last)
    else $error("Timeout abort carries a byte or an end flag.");

  a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_DATA && out_position == '0
      |-> out_byte_out == START_BYTE && out_frame_kind == 8'd0)
    else $error("Frame start reported with wrong byte or kind.");

endmodule

bind update_frame_deframer_unit udf_checker u_udf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_res   (out_event_res),
  .out_byte_out    (out_byte_out),
  .out_position    (out_position),
  .out_last        (out_last),
  .out_checksum_ok (out_checksum_ok),
  .out_frame_kind  (out_frame_kind)
);
`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for update_frame_deframer_unit
// Sends received bytes and timer ticks through the input channel, tracks the
// framing state alongside the block and compares every result transaction
// field by field. The timeout limit is changed between phases, and both
// channels idle and stall at random, with two long holds on the result side.
// ----------------------------------------------------------------------------
module tb;
  import udf_pkg::*;

  localparam int PHASE_ITEMS  = 265;
  localparam int DRAIN_CYCLES = 8;

  class frame_tracker;
    logic [3:0]        timeout_limit;
    bit                in_frame;
    logic [POS_W-1:0]  byte_count;
    logic [LEN_W-1:0]  expected_len;
    logic [7:0]        len_low;
    logic [7:0]        running_sum;
    logic [7:0]        type_held;
    bit                sum_matched;
    logic [TICK_W-1:0] tick_count;
    result_t           awaited_events[$];
    int                mismatch_count;

    function new();
      timeout_limit  = TIMEOUT_RESET;
      in_frame       = 1'b0;
      byte_count     = '0;
      expected_len   = '0;
      len_low        = '0;
      running_sum    = '0;
      sum_matched    = 1'b0;
      type_held      = '0;
      tick_count     = '0;
      mismatch_count = 0;
    endfunction

    function void note_event(event_t ev, logic [7:0] b, int pos, bit last, bit ok);
      result_t r;
      r.event_res   = ev;
      r.byte_out    = b;
      r.position    = POS_W'(pos);
      r.last        = last;
      r.checksum_ok = ok;
      r.frame_kind  = type_held;
      awaited_events.push_back(r);
    endfunction

    function void accept_item(logic func, logic [7:0] b);
      int pos;
      int nxt;
      if (func) begin
        if (!in_frame) return;
        nxt = tick_count + 1;
        if (nxt > timeout_limit) begin
          in_frame = 1'b0;
          note_event(EV_TIMEOUT, 8'h00, byte_count, 1'b0, 1'b0);
        end else begin
          tick_count = TICK_W'(nxt);
        end
        return;
      end
      if (!in_frame) begin
        if (b != START_BYTE) return;
        in_frame     = 1'b1;
        byte_count   = POS_W'(1);
        expected_len = '0;
        len_low      = '0;
        running_sum  = '0;
        sum_matched  = 1'b0;
        type_held    = '0;
        tick_count   = '0;
        note_event(EV_DATA, b, 0, 1'b0, 1'b0);
        return;
      end
      pos = byte_count;
      byte_count = byte_count + 1'b1;
      if (pos == TYPE_POS) type_held = b;
      if (pos == LEN_LOW_POS) len_low = b;
      if (pos == LEN_POS) begin
        if (type_held == FT_SHORT_A || type_held == FT_SHORT_B || type_held == FT_SHORT_C) begin
          expected_len = LEN_W'(SHORT_LEN);
        end else if (type_held == FT_LONG_A || type_held == FT_LONG_B) begin
          expected_len = LEN_W'(len_low) + (LEN_W'(b) << 8) + LEN_BIAS;
        end else begin
          in_frame = 1'b0;
          note_event(EV_BAD_TYPE, b, pos, 1'b0, 1'b0);
          return;
        end
        if (expected_len > MAX_LEN) begin
          in_frame = 1'b0;
          note_event(EV_LEN_OVF, b, pos, 1'b0, 1'b0);
          return;
        end
      end
      if (expected_len == 0 || pos + 3 <= expected_len) begin
        running_sum = running_sum + b;
      end else if (pos + 2 == expected_len) begin
        sum_matched = (running_sum == b);
      end else if (pos + 1 == expected_len) begin
        in_frame = 1'b0;
        if (b != END_BYTE) begin
          note_event(EV_BAD_END, b, pos, 1'b0, 1'b0);
        end else begin
          note_event(EV_DATA, b, pos, 1'b1, sum_matched);
        end
        return;
      end
      note_event(EV_DATA, b, pos, 1'b0, 1'b0);
    endfunction

    task flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
      $display("ERROR at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      mismatch_count++;
    endtask

    task check_event(result_t got);
      result_t want;
      if (awaited_events.size() == 0) begin
        flag_mismatch("unexpected result, byte_out", 16'h0, got.byte_out);
        return;
      end
      want = awaited_events.pop_front();
      if (got.event_res !== want.event_res)
        flag_mismatch("event_res", want.event_res, got.event_res);
      if (got.byte_out !== want.byte_out)
        flag_mismatch("byte_out", want.byte_out, got.byte_out);
      if (got.position !== want.position)
        flag_mismatch("position", want.position, got.position);
      if (got.last !== want.last)
        flag_mismatch("last", want.last, got.last);
      if (got.checksum_ok !== want.checksum_ok)
        flag_mismatch("checksum_ok", want.checksum_ok, got.checksum_ok);
      if (got.frame_kind !== want.frame_kind)
        flag_mismatch("frame_kind", want.frame_kind, got.frame_kind);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_func;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_event_res;
  logic [7:0] out_byte_out;
  logic [POS_W-1:0] out_position;
  logic out_last;
  logic out_checksum_ok;
  logic [7:0] out_frame_kind;
  logic cfg_wr_en;
  logic [3:0] cfg_wr_data;

  frame_tracker tracker = new();
  item_t        stim_q[$];
  logic [7:0]   frame_bytes[$];
  int           planned;
  bit           tx_burst;
  int           tx_run;

  update_frame_deframer_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_byte_out    (out_byte_out),
    .out_position    (out_position),
    .out_last        (out_last),
    .out_checksum_ok (out_checksum_ok),
    .out_frame_kind  (out_frame_kind),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic void add_item(logic func, logic [7:0] b, bit counted);
    item_t it;
    it.func    = func;
    it.rx_byte = b;
    stim_q.push_back(it);
    if (counted) planned++;
  endfunction

  function automatic logic [7:0] pick_content();
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0: return START_BYTE;
        1: return END_BYTE;
        2: return 8'h00;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_frame(logic [7:0] kind, int len);
    logic [15:0] body;
    frame_bytes.delete();
    frame_bytes.push_back(START_BYTE);
    frame_bytes.push_back(kind);
    for (int i = 2; i < len; i++) frame_bytes.push_back(pick_content());
    if ((kind == FT_LONG_A || kind == FT_LONG_B) && len >= 8) begin
      body = 16'(len - 8);
      frame_bytes[4] = body[7:0];
      frame_bytes[5] = body[15:8];
    end
  endfunction

  function automatic void seal_frame(bit good_sum, bit good_end);
    logic [7:0] sum;
    logic [7:0] tail;
    int len;
    len = frame_bytes.size();
    sum = '0;
    for (int i = 1; i <= len - 3; i++) sum = sum + frame_bytes[i];
    frame_bytes[len-2] = good_sum ? sum : sum + 8'($urandom_range(1, 255));
    if (good_end) begin
      frame_bytes[len-1] = END_BYTE;
    end else begin
      do tail = 8'($urandom_range(0, 255)); while (tail == END_BYTE);
      frame_bytes[len-1] = tail;
    end
  endfunction

  function automatic void queue_frame(int tick_pct);
    foreach (frame_bytes[i]) begin
      add_item(1'b0, frame_bytes[i], 1'b1);
      if ($urandom_range(0, 99) < tick_pct) add_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  function automatic int pick_long_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return MAX_LEN;
    if (r < 4) return $urandom_range(41, MAX_LEN - 1);
    return $urandom_range(8, 40);
  endfunction

  function automatic void plan_one();
    int pick;
    int tick_pct;
    int n;
    logic [7:0] kind;
    pick = $urandom_range(0, 99);
    tick_pct = ($urandom_range(0, 4) == 0) ? 25 : 2;
    if (pick < 40) begin
      build_frame(8'($urandom_range(FT_SHORT_A, FT_SHORT_C)), SHORT_LEN);
      seal_frame($urandom_range(0, 9) < 6, $urandom_range(0, 9) < 9);
      queue_frame(tick_pct);
    end else if (pick < 75) begin
      build_frame($urandom_range(0, 1) ? FT_LONG_A : FT_LONG_B, pick_long_len());
      seal_frame($urandom_range(0, 9) < 6, $urandom_range(0, 9) < 9);
      queue_frame(tick_pct);
    end else if (pick < 82) begin
      do kind = 8'($urandom_range(0, 255));
      while (kind == FT_LONG_A || kind == FT_LONG_B || kind == FT_SHORT_A ||
             kind == FT_SHORT_B || kind == FT_SHORT_C);
      build_frame(kind, 6);
      queue_frame(tick_pct);
    end else if (pick < 88) begin
      build_frame($urandom_range(0, 1) ? FT_LONG_A : FT_LONG_B, 6);
      if ($urandom_range(0, 1)) begin
        frame_bytes[4] = 8'd3;
        frame_bytes[5] = 8'd2;
      end else begin
        frame_bytes[4] = 8'($urandom_range(0, 255));
        frame_bytes[5] = 8'($urandom_range(3, 255));
      end
      queue_frame(tick_pct);
    end else if (pick < 94) begin
      n = $urandom_range(1, 6);
      repeat (n) add_item(1'b0, pick_content(), 1'b0);
    end else begin
      n = $urandom_range(1, 17);
      repeat (n) add_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  function automatic void plan_directed();
    build_frame(FT_SHORT_A, SHORT_LEN);
    frame_bytes[2] = 8'h00;
    frame_bytes[3] = 8'hFF;
    frame_bytes[4] = START_BYTE;
    frame_bytes[5] = END_BYTE;
    seal_frame(1'b1, 1'b1);
    queue_frame(0);
    add_item(1'b0, 8'h00, 1'b1);
    add_item(1'b1, 8'hFF, 1'b1);
    build_frame(8'hFF, 6);
    queue_frame(0);
    build_frame(FT_LONG_B, 6);
    frame_bytes[4] = 8'd3;
    frame_bytes[5] = 8'd2;
    queue_frame(0);
  endfunction

  task automatic drive_items();
    item_t it;
    int gap;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      gap = tx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_func    <= it.func;
      in_rx_byte <= it.rx_byte;
      do @(posedge clk); while (in_stall !== 1'b0);
      tracker.accept_item(it.func, it.rx_byte);
      tx_run--;
      if (tx_run <= 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        tx_run = $urandom_range(10, 60);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [3:0] limit);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.timeout_limit = limit;
    @(posedge clk);
  endtask

  initial begin
    logic [3:0] limits[5];
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_func     <= 1'b0;
    in_rx_byte  <= 8'h00;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 4'h0;
    planned  = 0;
    tx_burst = 1'b0;
    tx_run   = $urandom_range(10, 60);
    limits[0] = 4'd15;
    limits[1] = 4'd1;
    limits[2] = 4'd0;
    limits[3] = 4'($urandom_range(2, 14));
    limits[4] = 4'd7;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    plan_directed();
    drive_items();
    for (int phase = 0; phase <= 5; phase++) begin
      if (phase > 0) begin
        wait_idle();
        write_timeout(limits[phase-1]);
      end
      planned = 0;
      while (planned < PHASE_ITEMS) plan_one();
      drive_items();
    end
    wait_idle();
    if (tracker.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    result_t got;
    int hold;
    int taken;
    bit rx_burst;
    int rx_run;
    out_stall <= 1'b0;
    taken    = 0;
    rx_burst = 1'b0;
    rx_run   = $urandom_range(10, 60);
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken == 40 || taken == 600) begin
        hold = 150;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got.event_res   = event_t'(out_event_res);
      got.byte_out    = out_byte_out;
      got.position    = out_position;
      got.last        = out_last;
      got.checksum_ok = out_checksum_ok;
      got.frame_kind  = out_frame_kind;
      tracker.check_event(got);
      taken++;
      rx_run--;
      if (rx_run <= 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
        rx_run = $urandom_range(10, 60);
      end
    end
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/udf_pkg.sv
src/udf_in_stage.sv
src/udf_core.sv
src/udf_out_stage.sv
src/update_frame_deframer_unit.sv
src/udf_checker.sv
sim/tb.sv
